// ===== rtl/sdre_pkg.sv =====
// sdre_pkg: shared constants and types for the signed radix digit emitter
// used by the top level and its port checker; no dependencies
`timescale 1ns / 1ps

package sdre_pkg;

    // opcode carried in tuser of the input stream
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // field widths fixed by the interface
    localparam int IDX_W     = 6;   // alphabet position
    localparam int SYM_W     = 8;   // symbol byte
    localparam int BASE_W    = 7;   // base_len register
    localparam int DIGIT_W   = 6;   // one digit index, below MAX_RADIX
    localparam int MAX_RADIX = 64;  // alphabet depth

    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS = 4;

    typedef logic [SYM_W-1:0] t_char;

    localparam t_char CHAR_NUL   = 8'h00;
    localparam t_char CHAR_PLUS  = 8'h2B;
    localparam t_char CHAR_MINUS = 8'h2D;

endpackage

// ===== rtl/sdre_ram.sv =====
// sdre_ram: generic simple dual-port ram, one write port, one registered read port
// no package dependencies
`timescale 1ns / 1ps

module sdre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/signed_radix_digit_emitter.sv =====
// signed_radix_digit_emitter: top level, sequencer around the alphabet and digit memories
// depends on sdre_pkg and sdre_ram
`timescale 1ns / 1ps

// channel    | dir | signals                          | item contents
// -----------+-----+----------------------------------+---------------------------------------
// s (items)  | in  | i_s_tvalid o_s_tready i_s_tdata  | tuser: opcode; tdata: symbol_index,
//            |     | i_s_tuser                        |   symbol_char, number (low bits up)
// m (chars)  | out | o_m_tvalid i_m_tready o_m_tdata  | tdata: out_char; tlast: last
//            |     | o_m_tlast                        |
// cfg        | in  | i_cfg_valid o_cfg_ready          | i_cfg_data: base_len
//            |     | i_cfg_data                       |
//
// flow: a load item is written to the alphabet memory as it is accepted. a convert item
//   is dispatched on the alphabet verdict, then divided digit by digit (4 quotient bits a
//   cycle against the 7-bit radix), then each character goes through the digit stack read
//   and the alphabet read; a negative number first emits a minus sign.
// the alphabet check reads the alphabet memory once a cycle; its verdict is kept until
//   the next load or base_len write.
// reset clears base_len, the check verdict and the sequencer; memories are not cleared.
// the output register holds one character; the sequencer waits on it, and a new item
//   is accepted while the final character of the previous one is still waiting.

module signed_radix_digit_emitter #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: symbol_index [5:0], symbol_char [13:6], number above, zero pad to bytes
    input  logic [((sdre_pkg::IDX_W + sdre_pkg::SYM_W + NUMBER_WIDTH + 7) / 8) * 8 - 1:0]
                                        i_s_tdata,
    // tuser: opcode
    input  logic                        i_s_tuser,
    // result characters
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // tdata: out_char
    output logic [sdre_pkg::SYM_W-1:0]  o_m_tdata,
    output logic                        o_m_tlast,
    // base_len register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sdre_pkg::BASE_W-1:0] i_cfg_data
);

    localparam int NUM_LSB = sdre_pkg::IDX_W + sdre_pkg::SYM_W;
    // dividend padded to whole divider cycles
    localparam int QW      = ((NUMBER_WIDTH + sdre_pkg::DIV_STEPS - 1) / sdre_pkg::DIV_STEPS)
                             * sdre_pkg::DIV_STEPS;
    localparam int DIV_CYC = QW / sdre_pkg::DIV_STEPS;
    localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int SP_W    = $clog2(NUMBER_WIDTH);       // digit stack address
    localparam int CNT_W   = $clog2(NUMBER_WIDTH + 1);   // digit count
    localparam int AA_W    = $clog2(sdre_pkg::MAX_RADIX); // alphabet address

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;  // take items
    localparam logic [3:0] S_CHK  = 4'd1;  // dispatch on alphabet verdict
    localparam logic [3:0] S_VI   = 4'd2;  // check symbol i, start pair scan
    localparam logic [3:0] S_VJ   = 4'd3;  // compare symbol j against symbol i
    localparam logic [3:0] S_SIGN = 4'd4;  // emit minus sign
    localparam logic [3:0] S_DIV  = 4'd5;  // divide quotient by radix
    localparam logic [3:0] S_ERS  = 4'd6;  // read digit stack
    localparam logic [3:0] S_ERA  = 4'd7;  // read alphabet at digit
    localparam logic [3:0] S_ELD  = 4'd8;  // load output register

    logic [3:0]                  r_state, n_state;
    logic [sdre_pkg::BASE_W-1:0] r_base, n_base;
    logic                        r_ok_valid, n_ok_valid;  // verdict is current
    logic                        r_ok, n_ok;
    logic                        r_neg, n_neg;
    logic [QW-1:0]               r_quot, n_quot;
    logic [sdre_pkg::DIGIT_W-1:0] r_rem, n_rem;
    logic [STEP_W-1:0]           r_step, n_step;
    logic [CNT_W-1:0]            r_ndig, n_ndig;
    logic [sdre_pkg::BASE_W-1:0] r_i, n_i;
    logic [sdre_pkg::BASE_W-1:0] r_j, n_j;
    sdre_pkg::t_char             r_ci, n_ci;
    logic                        r_out_valid;
    sdre_pkg::t_char             r_out_data;
    logic                        r_out_last;

    // memory ports
    logic                         w_a_wr_en, w_a_rd_en;
    logic [AA_W-1:0]              w_a_wr_addr, w_a_rd_addr;
    sdre_pkg::t_char              w_a_wr_data, w_a_rd_data;
    logic                         w_s_wr_en, w_s_rd_en;
    logic [SP_W-1:0]              w_s_wr_addr, w_s_rd_addr;
    logic [sdre_pkg::DIGIT_W-1:0] w_s_wr_data, w_s_rd_data;

    logic                          w_s_acc;
    logic                          w_cfg_acc;
    logic                          w_out_free;
    logic                          w_out_load;
    sdre_pkg::t_char               w_out_data;
    logic                          w_out_last;
    logic [sdre_pkg::IDX_W-1:0]    w_idx;
    sdre_pkg::t_char               w_sym;
    logic [NUMBER_WIDTH-1:0]       w_num;
    logic [NUMBER_WIDTH-1:0]       w_mag;
    logic [QW-1:0]                 w_dq;
    logic [sdre_pkg::DIGIT_W-1:0]  w_dr;
    logic [sdre_pkg::BASE_W-1:0]   w_i_inc, w_j_inc;
    logic [CNT_W-1:0]              w_ndig_dec;

    assign w_idx = i_s_tdata[sdre_pkg::IDX_W-1:0];
    assign w_sym = i_s_tdata[sdre_pkg::IDX_W +: sdre_pkg::SYM_W];
    assign w_num = i_s_tdata[NUM_LSB +: NUMBER_WIDTH];
    // the most negative value maps onto its unsigned magnitude
    assign w_mag = w_num[NUMBER_WIDTH-1] ? (~w_num + 1'b1) : w_num;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid & o_s_tready;
    assign w_cfg_acc   = i_cfg_valid & o_cfg_ready;
    assign w_out_free  = ~r_out_valid | i_m_tready;

    assign w_i_inc    = r_i + 1'b1;
    assign w_j_inc    = r_j + 1'b1;
    assign w_ndig_dec = r_ndig - 1'b1;

    // restoring division, DIV_STEPS quotient bits per cycle; remainder stays below radix
    always_comb begin
        logic [sdre_pkg::DIGIT_W:0]   t;
        logic [QW-1:0]                q;
        logic [sdre_pkg::DIGIT_W-1:0] rm;
        q  = r_quot;
        rm = r_rem;
        for (int k = 0; k < sdre_pkg::DIV_STEPS; k++) begin
            t = {rm, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= r_base) begin
                t    = t - r_base;
                q[0] = 1'b1;
            end
            rm = t[sdre_pkg::DIGIT_W-1:0];
        end
        w_dq = q;
        w_dr = rm;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_ok_valid = r_ok_valid;
        n_ok       = r_ok;
        n_neg      = r_neg;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_step     = r_step;
        n_ndig     = r_ndig;
        n_i        = r_i;
        n_j        = r_j;
        n_ci       = r_ci;

        w_a_wr_en   = 1'b0;
        w_a_wr_addr = w_idx;
        w_a_wr_data = w_sym;
        w_a_rd_en   = 1'b0;
        w_a_rd_addr = '0;
        w_s_wr_en   = 1'b0;
        w_s_wr_addr = r_ndig[SP_W-1:0];
        w_s_wr_data = w_dr;
        w_s_rd_en   = 1'b0;
        w_s_rd_addr = w_ndig_dec[SP_W-1:0];

        w_out_load = 1'b0;
        w_out_data = sdre_pkg::CHAR_MINUS;
        w_out_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    if (i_s_tuser == sdre_pkg::OP_LOAD) begin
                        w_a_wr_en  = 1'b1;
                        n_ok_valid = 1'b0;
                    end else begin
                        n_neg   = w_num[NUMBER_WIDTH-1];
                        n_quot  = QW'(w_mag);
                        n_rem   = '0;
                        n_step  = '0;
                        n_ndig  = '0;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (r_ok_valid) begin
                    if (!r_ok) begin
                        n_state = S_IDLE;
                    end else if (r_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIV;
                    end
                end else if (r_base < sdre_pkg::BASE_W'(2) ||
                             r_base > sdre_pkg::BASE_W'(sdre_pkg::MAX_RADIX)) begin
                    n_ok_valid = 1'b1;
                    n_ok       = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    w_a_rd_en   = 1'b1;
                    w_a_rd_addr = '0;
                    n_i         = '0;
                    n_state     = S_VI;
                end
            end
            S_VI: begin
                n_ci = w_a_rd_data;
                if (w_a_rd_data inside {sdre_pkg::CHAR_NUL, sdre_pkg::CHAR_PLUS,
                                        sdre_pkg::CHAR_MINUS}) begin
                    n_ok_valid = 1'b1;
                    n_ok       = 1'b0;
                    n_state    = S_IDLE;
                end else if (w_i_inc < r_base) begin
                    w_a_rd_en   = 1'b1;
                    w_a_rd_addr = w_i_inc[AA_W-1:0];
                    n_j         = w_i_inc;
                    n_state     = S_VJ;
                end else begin
                    // last symbol passed, every pair already compared
                    n_ok_valid = 1'b1;
                    n_ok       = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_VJ: begin
                w_a_rd_en = 1'b1;
                if (w_a_rd_data == r_ci) begin
                    w_a_rd_en  = 1'b0;
                    n_ok_valid = 1'b1;
                    n_ok       = 1'b0;
                    n_state    = S_IDLE;
                end else if (w_j_inc < r_base) begin
                    w_a_rd_addr = w_j_inc[AA_W-1:0];
                    n_j         = w_j_inc;
                end else begin
                    w_a_rd_addr = w_i_inc[AA_W-1:0];
                    n_i         = w_i_inc;
                    n_state     = S_VI;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                n_quot = w_dq;
                n_rem  = w_dr;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_CYC - 1)) begin
                    // digit done: push remainder, restart on the quotient
                    w_s_wr_en = 1'b1;
                    n_ndig    = r_ndig + 1'b1;
                    n_rem     = '0;
                    n_step    = '0;
                    if (w_dq == '0 || r_ndig == CNT_W'(NUMBER_WIDTH - 1)) begin
                        n_state = S_ERS;
                    end
                end
            end
            S_ERS: begin
                if (w_out_free) begin
                    w_s_rd_en = 1'b1;
                    n_ndig    = w_ndig_dec;
                    n_state   = S_ERA;
                end
            end
            S_ERA: begin
                w_a_rd_en   = 1'b1;
                w_a_rd_addr = w_s_rd_data;
                n_state     = S_ELD;
            end
            S_ELD: begin
                // output register is known empty since the stack read
                w_out_load = 1'b1;
                w_out_data = w_a_rd_data;
                w_out_last = (r_ndig == '0);
                n_state    = (r_ndig == '0) ? S_IDLE : S_ERS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cfg_acc) begin
            n_base     = i_cfg_data;
            n_ok_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_ok_valid  <= 1'b0;
            r_ok        <= 1'b0;
            r_quot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_ok_valid <= n_ok_valid;
            r_ok       <= n_ok;
            r_quot     <= n_quot;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_ndig <= n_ndig;
        r_i    <= n_i;
        r_j    <= n_j;
        r_ci   <= n_ci;
        if (w_out_load) begin
            r_out_data <= w_out_data;
            r_out_last <= w_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // alphabet symbols
    sdre_ram #(
        .WIDTH(sdre_pkg::SYM_W),
        .DEPTH(sdre_pkg::MAX_RADIX)
    ) u_alpha_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_a_wr_en),
        .i_wr_addr (w_a_wr_addr),
        .i_wr_data (w_a_wr_data),
        .i_rd_en   (w_a_rd_en),
        .i_rd_addr (w_a_rd_addr),
        .o_rd_data (w_a_rd_data)
    );

    // digit indices, least significant first
    sdre_ram #(
        .WIDTH(sdre_pkg::DIGIT_W),
        .DEPTH(NUMBER_WIDTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_s_wr_en),
        .i_wr_addr (w_s_wr_addr),
        .i_wr_data (w_s_wr_data),
        .i_rd_en   (w_s_rd_en),
        .i_rd_addr (w_s_rd_addr),
        .o_rd_data (w_s_rd_data)
    );

endmodule

// ===== rtl/sdre_chk.sv =====
// sdre_chk: port-level checker for signed_radix_digit_emitter, bound to the top level
// depends on sdre_pkg
`timescale 1ns / 1ps

module sdre_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        i_s_tuser,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [sdre_pkg::SYM_W-1:0]  o_m_tdata,
    input logic                        o_m_tlast
);

    logic w_s_acc;
    assign w_s_acc = i_s_tvalid & o_s_tready;

    // a waiting character stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    // a load emits nothing
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && i_s_tuser == sdre_pkg::OP_LOAD && !o_m_tvalid |=> !o_m_tvalid)
        else $error("load item produced output");

    // a conversion blocks further items until it is done
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && i_s_tuser == sdre_pkg::OP_CONVERT |=> !o_s_tready)
        else $error("item accepted during conversion");

    // the minus sign only leads a conversion, a valid alphabet never holds it
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata == sdre_pkg::CHAR_MINUS |-> !o_m_tlast)
        else $error("minus sign ended a conversion");

endmodule

bind signed_radix_digit_emitter sdre_chk u_sdre_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);

// ===== tb/signed_radix_digit_emitter_tb.sv =====
// signed_radix_digit_emitter_tb: self-checking bench for the signed radix digit emitter
// drives alphabet loads, conversions and base_len writes, predicts every character
// depends on sdre_pkg and signed_radix_digit_emitter
`timescale 1ns / 1ps

module signed_radix_digit_emitter_tb;

    localparam int NUM_W          = 32;
    localparam int TDATA_W        = ((sdre_pkg::IDX_W + sdre_pkg::SYM_W + NUM_W + 7) / 8) * 8;
    localparam int PAD_W          = TDATA_W - sdre_pkg::IDX_W - sdre_pkg::SYM_W - NUM_W;
    // drain pause, longer than an alphabet check over 64 symbols
    localparam int DRAIN_PAUSE    = 2500;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        sdre_pkg::t_char ch;
        logic            last;
    } t_emitted_char;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_s_tvalid  = 1'b0;
    logic                        o_s_tready;
    logic [TDATA_W-1:0]          i_s_tdata   = '0;
    logic                        i_s_tuser   = sdre_pkg::OP_LOAD;
    logic                        o_m_tvalid;
    logic                        i_m_tready  = 1'b0;
    logic [sdre_pkg::SYM_W-1:0]  o_m_tdata;
    logic                        o_m_tlast;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [sdre_pkg::BASE_W-1:0] i_cfg_data  = '0;

    // predictor copy of the block state, updated at each accepted item and base_len write
    sdre_pkg::t_char             sym_table [sdre_pkg::MAX_RADIX];
    logic [sdre_pkg::BASE_W-1:0] radix_reg = '0;
    t_emitted_char               pending_chars [$];

    // stimulus-side view of the alphabet, used to pick legal or broken symbols
    sdre_pkg::t_char             stim_table [sdre_pkg::MAX_RADIX];
    int                          stim_radix = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_fail        = 0;
    int n_loads       = 0;
    int n_converts    = 0;
    int n_silent      = 0;
    int n_chars       = 0;
    int idle_cycles   = 0;

    signed_radix_digit_emitter #(
        .NUMBER_WIDTH (NUM_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic bit alphabet_usable();
        if (radix_reg < 2 || radix_reg > sdre_pkg::MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < radix_reg; i++) begin
            if (sym_table[i] == sdre_pkg::CHAR_NUL || sym_table[i] == sdre_pkg::CHAR_PLUS ||
                sym_table[i] == sdre_pkg::CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < radix_reg; j++)
                if (sym_table[j] == sym_table[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // digits of one accepted conversion, pushed most significant first
    task automatic predict_digits(input logic signed [NUM_W-1:0] num);
        logic [NUM_W-1:0]            mag;
        logic [sdre_pkg::DIGIT_W-1:0] digits [NUM_W];
        int                          ndig;
        ndig = 0;
        if (!alphabet_usable()) begin
            n_silent++;
            return;
        end
        if (num == 0) begin
            pending_chars.push_back('{ch: sym_table[0], last: 1'b1});
            return;
        end
        mag = num;
        if (num[NUM_W-1]) begin
            pending_chars.push_back('{ch: sdre_pkg::CHAR_MINUS, last: 1'b0});
            mag = -mag;     // the most negative value stays 2^31 as unsigned
        end
        while (mag != 0) begin
            digits[ndig] = sdre_pkg::DIGIT_W'(mag % radix_reg);
            mag = mag / radix_reg;
            ndig++;
        end
        for (int i = ndig - 1; i >= 0; i--)
            pending_chars.push_back('{ch: sym_table[digits[i]], last: (i == 0)});
    endtask

    // ---------------------------------------------------------------
    // monitor: prediction on accepted items, then check of accepted characters
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        t_emitted_char want;
        logic          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                moved = 1'b1;
                if (i_s_tuser == sdre_pkg::OP_LOAD) begin
                    n_loads++;
                    sym_table[i_s_tdata[sdre_pkg::IDX_W-1:0]] =
                        i_s_tdata[sdre_pkg::IDX_W +: sdre_pkg::SYM_W];
                end else begin
                    n_converts++;
                    predict_digits(i_s_tdata[sdre_pkg::IDX_W + sdre_pkg::SYM_W +: NUM_W]);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                radix_reg = i_cfg_data;
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                n_chars++;
                if (pending_chars.size() == 0) begin
                    $error("unexpected item: out_char %h last %b", o_m_tdata, o_m_tlast);
                    n_fail++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_m_tdata !== want.ch) begin
                        $error("out_char expected %h actual %h", want.ch, o_m_tdata);
                        n_fail++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $error("last expected %b actual %b", want.last, o_m_tlast);
                        n_fail++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic send_item(input logic op, input logic [sdre_pkg::IDX_W-1:0] idx,
                             input sdre_pkg::t_char sym,
                             input logic signed [NUM_W-1:0] num);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{PAD_W{1'b0}}, num, sym, idx};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_load(input int idx, input sdre_pkg::t_char sym);
        stim_table[idx] = sym;
        send_item(sdre_pkg::OP_LOAD, sdre_pkg::IDX_W'(idx), sym, $urandom);
    endtask

    // unused fields get random bits so every tdata bit but the zero pad toggles
    task automatic send_convert(input logic signed [NUM_W-1:0] num);
        send_item(sdre_pkg::OP_CONVERT, sdre_pkg::IDX_W'($urandom),
                  sdre_pkg::t_char'($urandom), num);
    endtask

    // base_len changes only once the block is drained and any silent check has ended
    task automatic write_radix(input int value);
        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sdre_pkg::BASE_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        stim_radix = value;
    endtask

    // a legal symbol not yet anywhere in the alphabet
    function automatic sdre_pkg::t_char fresh_symbol();
        sdre_pkg::t_char s;
        bit              taken;
        do begin
            s = sdre_pkg::t_char'($urandom_range(255, 1));
            taken = (s == sdre_pkg::CHAR_PLUS) || (s == sdre_pkg::CHAR_MINUS);
            for (int i = 0; i < sdre_pkg::MAX_RADIX; i++)
                if (stim_table[i] == s)
                    taken = 1'b1;
        end while (taken);
        return s;
    endfunction

    function automatic logic signed [NUM_W-1:0] rand_number();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {1'b1, {(NUM_W-1){1'b0}}};
            2:       return {1'b0, {(NUM_W-1){1'b1}}};
            3, 4:    return NUM_W'($urandom_range(600)) - NUM_W'(300);
            default: return $signed(NUM_W'($urandom)) >>> $urandom_range(NUM_W - 1);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every position written before any conversion, all symbols distinct and legal
    task automatic test_fill_alphabet();
        for (int i = 0; i < sdre_pkg::MAX_RADIX; i++)
            stim_table[i] = sdre_pkg::CHAR_NUL;
        for (int i = 0; i < sdre_pkg::MAX_RADIX; i++)
            send_load(i, (i == 0) ? 8'h01 : (i == 1) ? 8'hFF : fresh_symbol());
    endtask

    // radix below two gives no output
    task automatic test_short_radix();
        write_radix(0);
        send_convert(5);
        write_radix(1);
        send_convert(0);
    endtask

    // zero, plus and minus one, both ends of the number range, smallest and largest radix
    task automatic test_conversion_extremes();
        write_radix(2);
        send_convert(0);
        send_convert(1);
        send_convert(-1);
        send_convert(32'sh7FFF_FFFF);
        send_convert(32'sh8000_0000);
        write_radix(sdre_pkg::MAX_RADIX);
        send_convert(32'sh7FFF_FFFF);
        send_convert(32'sh8000_0000);
        send_convert(-64);
        send_convert(63);
        write_radix(10);
        send_convert(12345);
        send_convert(-987654321);
    endtask

    // a plus, a minus or a repeated symbol among the active ones blocks conversion
    task automatic test_bad_symbols();
        sdre_pkg::t_char saved;
        saved = stim_table[3];
        send_load(3, sdre_pkg::CHAR_PLUS);
        send_convert(1);
        send_load(3, sdre_pkg::CHAR_MINUS);
        send_convert(-1);
        send_load(3, stim_table[7]);
        send_convert(42);
        send_load(3, saved);
        send_convert(0);
    endtask

    // mostly conversions on a legal alphabet, some legal reloads, some broken-then-repaired
    task automatic test_random_traffic();
        int              n;
        int              k;
        int              j;
        int              extra;
        sdre_pkg::t_char saved;
        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = (stage == 0) ? 17 : (stage == 1) ? 84 : 0;
            recv_idle_pct = (stage == 0) ? 84 : (stage == 1) ? 17 : 0;
            for (int sub = 0; sub < 3; sub++) begin
                if (sub == 0)
                    write_radix($urandom_range(12, 2));
                else if (sub == 1)
                    write_radix($urandom_range(40, 13));
                else
                    write_radix((stage == 0) ? 2 : (stage == 1) ? sdre_pkg::MAX_RADIX :
                                $urandom_range(sdre_pkg::MAX_RADIX, 41));
                n = 0;
                while (n < 21) begin
                    k = $urandom_range(99);
                    if (k < 65) begin
                        send_convert(rand_number());
                        n++;
                    end else if (k < 85) begin
                        send_load($urandom_range(sdre_pkg::MAX_RADIX - 1), fresh_symbol());
                        n++;
                    end else begin
                        // break one active symbol, try to convert, then put it back
                        k = $urandom_range(stim_radix - 1);
                        saved = stim_table[k];
                        case ($urandom_range(2))
                            0: send_load(k, sdre_pkg::CHAR_PLUS);
                            1: send_load(k, sdre_pkg::CHAR_MINUS);
                            default: begin
                                do j = $urandom_range(stim_radix - 1); while (j == k);
                                send_load(k, stim_table[j]);
                            end
                        endcase
                        extra = $urandom_range(2, 1);
                        repeat (extra) send_convert(rand_number());
                        send_load(k, saved);
                        n += extra + 2;
                    end
                end
            end
        end
    endtask

    initial begin
        send_idle_pct = 17;
        recv_idle_pct = 84;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_alphabet();
        test_short_radix();
        test_conversion_extremes();
        test_bad_symbols();
        test_random_traffic();

        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);

        $display("covered %0d symbol loads and %0d conversions (%0d blocked by the alphabet)",
                 n_loads, n_converts, n_silent);
        $display("checked %0d characters over radix 0 to %0d with both sides stalling",
                 n_chars, sdre_pkg::MAX_RADIX);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== signed_radix_digit_emitter.f =====
rtl/sdre_pkg.sv
rtl/sdre_ram.sv
rtl/signed_radix_digit_emitter.sv
rtl/sdre_chk.sv
tb/signed_radix_digit_emitter_tb.sv
